// ----- design/lcrng_pkg.sv -----
package lcrng_pkg;

  localparam int unsigned RowW    = 11;
  localparam int unsigned ColW    = 12;
  localparam int unsigned SlotW   = 3;
  localparam int unsigned LocW    = 9;
  localparam int unsigned QtrW    = 7;
  localparam int unsigned KindW   = 4;
  localparam int unsigned CgrpW   = 3;
  localparam logic [1:0]  NumGrps = 2'd3;
  localparam logic [KindW-1:0] KindIdent = 4'd0;

  typedef struct packed {
    logic [1:0]       grp;
    logic [LocW-1:0]  loc;
    logic [SlotW-1:0] slot;
    logic             last;
  } issue_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [CgrpW-1:0] cgrp;
  } edge_spec_t;

  function automatic logic [1:0] theta_f(input logic [2:0] t);
    logic [1:0] r;
    case (t)
      3'd0:    r = 2'd3;
      3'd1:    r = 2'd0;
      3'd2:    r = 2'd1;
      3'd3:    r = 2'd2;
      3'd4:    r = 2'd2;
      3'd5:    r = 2'd3;
      3'd6:    r = 2'd0;
      default: r = 2'd1;
    endcase
    return r;
  endfunction

  function automatic logic [QtrW-1:0] phi_f(input logic [2:0] t, input logic [1:0] q);
    logic [QtrW-1:0] r;
    case ({t, q})
      5'd0:    r = 7'd16;
      5'd1:    r = 7'd0;
      5'd2:    r = 7'd0;
      5'd3:    r = 7'd0;
      5'd4:    r = 7'd103;
      5'd5:    r = 7'd53;
      5'd6:    r = 7'd8;
      5'd7:    r = 7'd35;
      5'd8:    r = 7'd105;
      5'd9:    r = 7'd74;
      5'd10:   r = 7'd119;
      5'd11:   r = 7'd97;
      5'd12:   r = 7'd0;
      5'd13:   r = 7'd45;
      5'd14:   r = 7'd89;
      5'd15:   r = 7'd112;
      5'd16:   r = 7'd50;
      5'd17:   r = 7'd47;
      5'd18:   r = 7'd31;
      5'd19:   r = 7'd64;
      5'd20:   r = 7'd29;
      5'd21:   r = 7'd0;
      5'd22:   r = 7'd122;
      5'd23:   r = 7'd93;
      5'd24:   r = 7'd115;
      5'd25:   r = 7'd59;
      5'd26:   r = 7'd1;
      5'd27:   r = 7'd99;
      5'd28:   r = 7'd30;
      5'd29:   r = 7'd102;
      5'd30:   r = 7'd69;
      default: r = 7'd94;
    endcase
    return r;
  endfunction

  function automatic logic [SlotW-1:0] edge_count_f(input logic [1:0] grp);
    logic [SlotW-1:0] r;
    case (grp)
      2'd0:    r = 3'd3;
      default: r = 3'd6;
    endcase
    return r;
  endfunction

  function automatic edge_spec_t layout_f(input logic [1:0] grp, input logic [SlotW-1:0] slot);
    edge_spec_t r;
    case ({grp, slot})
      5'b00_000: r = '{kind: 4'd0, cgrp: 3'd2};
      5'b00_001: r = '{kind: 4'd0, cgrp: 3'd4};
      5'b00_010: r = '{kind: 4'd1, cgrp: 3'd4};
      5'b01_000: r = '{kind: 4'd0, cgrp: 3'd0};
      5'b01_001: r = '{kind: 4'd0, cgrp: 3'd1};
      5'b01_010: r = '{kind: 4'd0, cgrp: 3'd3};
      5'b01_011: r = '{kind: 4'd2, cgrp: 3'd4};
      5'b01_100: r = '{kind: 4'd3, cgrp: 3'd4};
      5'b01_101: r = '{kind: 4'd4, cgrp: 3'd4};
      5'b10_000: r = '{kind: 4'd0, cgrp: 3'd0};
      5'b10_001: r = '{kind: 4'd5, cgrp: 3'd1};
      5'b10_010: r = '{kind: 4'd6, cgrp: 3'd1};
      5'b10_011: r = '{kind: 4'd7, cgrp: 3'd3};
      5'b10_100: r = '{kind: 4'd8, cgrp: 3'd3};
      5'b10_101: r = '{kind: 4'd0, cgrp: 3'd4};
      default:   r = '{kind: 4'd0, cgrp: 3'd0};
    endcase
    return r;
  endfunction

endpackage

// ----- design/lcrng_seq.sv -----
module lcrng_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lcrng_pkg::RowW-1:0]   in_row_index,
  input  logic                         advance,
  output logic                         issue_valid,
  output lcrng_pkg::issue_t            issue
);

  logic                          busy_r, busy_nxt;
  logic [1:0]                    grp_r, grp_nxt;
  logic [lcrng_pkg::LocW-1:0]    loc_r, loc_nxt;
  logic [lcrng_pkg::SlotW-1:0]   slot_r, slot_nxt;
  logic                          last_slot;
  logic                          accept;
  logic [1:0]                    in_grp;

  assign in_grp    = in_row_index[lcrng_pkg::RowW-1 -: 2];
  assign last_slot = (slot_r + 3'd1) == lcrng_pkg::edge_count_f(grp_r);
  assign in_stall  = busy_r && !(advance && last_slot);
  assign accept    = in_valid && !in_stall;

  assign issue_valid = busy_r;
  assign issue.grp   = grp_r;
  assign issue.loc   = loc_r;
  assign issue.slot  = slot_r;
  assign issue.last  = last_slot;

  always_comb begin
    busy_nxt = busy_r;
    grp_nxt  = grp_r;
    loc_nxt  = loc_r;
    slot_nxt = slot_r;
    if (busy_r && advance) begin
      if (last_slot) begin
        busy_nxt = 1'b0;
      end else begin
        slot_nxt = slot_r + 3'd1;
      end
    end
    if (accept) begin
      busy_nxt = in_grp < lcrng_pkg::NumGrps;
      grp_nxt  = in_grp;
      loc_nxt  = in_row_index[lcrng_pkg::LocW-1:0];
      slot_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    grp_r  <= grp_nxt;
    loc_r  <= loc_nxt;
    slot_r <= slot_nxt;
  end

  a_busy_grp: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> grp_r != 2'd3) else $error("busy on an out of range row");

  a_busy_slot: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> slot_r < lcrng_pkg::edge_count_f(grp_r))
    else $error("slot past row degree");

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> busy_r) else $error("stall while idle");

endmodule

// ----- design/lcrng_pipe.sv -----
module lcrng_pipe (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          issue_valid,
  input  lcrng_pkg::issue_t             issue,
  output logic                          advance,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lcrng_pkg::ColW-1:0]    out_column_index,
  output logic [lcrng_pkg::SlotW-1:0]   out_edge_slot,
  output logic                          out_last_edge
);

  logic                          v1_r, v2_r, v3_r;
  lcrng_pkg::edge_spec_t         spec1_r;
  logic [lcrng_pkg::LocW-1:0]    loc1_r;
  logic [lcrng_pkg::SlotW-1:0]   slot1_r, slot2_r, slot3_r;
  logic                          last1_r, last2_r, last3_r;
  logic [lcrng_pkg::CgrpW-1:0]   cgrp2_r;
  logic [lcrng_pkg::LocW-1:0]    local2_r, local_nxt;
  logic [lcrng_pkg::ColW-1:0]    col3_r;
  logic [2:0]                    t1;
  logic [1:0]                    q1;

  assign advance = !v3_r || !out_stall;

  assign q1 = loc1_r[lcrng_pkg::LocW-1 -: 2];
  assign t1 = 3'(spec1_r.kind - 4'd1);

  always_comb begin
    if (spec1_r.kind == lcrng_pkg::KindIdent) begin
      local_nxt = loc1_r;
    end else begin
      local_nxt = {2'(lcrng_pkg::theta_f(t1) + q1),
                   7'(lcrng_pkg::phi_f(t1, q1) + loc1_r[lcrng_pkg::QtrW-1:0])};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (advance) begin
      v1_r <= issue_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    if (advance) begin
      spec1_r  <= lcrng_pkg::layout_f(issue.grp, issue.slot);
      loc1_r   <= issue.loc;
      slot1_r  <= issue.slot;
      last1_r  <= issue.last;
      cgrp2_r  <= spec1_r.cgrp;
      local2_r <= local_nxt;
      slot2_r  <= slot1_r;
      last2_r  <= last1_r;
      col3_r   <= {cgrp2_r, local2_r};
      slot3_r  <= slot2_r;
      last3_r  <= last2_r;
    end
  end

  assign out_valid        = v3_r;
  assign out_column_index = col3_r;
  assign out_edge_slot    = slot3_r;
  assign out_last_edge    = last3_r;

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> col3_r < 12'd2560) else $error("column out of range");

  a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && last3_r) |-> (slot3_r == 3'd2 || slot3_r == 3'd5))
    else $error("last edge at unexpected slot");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> slot3_r <= 3'd5) else $error("slot out of range");

endmodule

// ----- design/ldpc_check_row_neighbour_generator_core.sv -----
// path: a row's first column is registered by the sequencer, then pipe stages spec1,
// local2 and col3; throughput: one column per cycle while out_stall is low; the
// sequencer issues a row's edges slot by slot (3 in group 0, 6 in groups 1 and 2) and
// takes the next row as it issues the last edge; rows of 1536 and above are taken and produce nothing
// reset: synchronous active-low rst_n clears all valid state; no clearing pass
module ldpc_check_row_neighbour_generator_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lcrng_pkg::RowW-1:0]    in_row_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lcrng_pkg::ColW-1:0]    out_column_index,
  output logic [lcrng_pkg::SlotW-1:0]   out_edge_slot,
  output logic                          out_last_edge
);

  logic               advance;
  logic               issue_valid;
  lcrng_pkg::issue_t  issue;

  lcrng_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_row_index (in_row_index),
    .advance      (advance),
    .issue_valid  (issue_valid),
    .issue        (issue)
  );

  lcrng_pipe u_pipe (
    .clk              (clk),
    .rst_n            (rst_n),
    .issue_valid      (issue_valid),
    .issue            (issue),
    .advance          (advance),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_column_index (out_column_index),
    .out_edge_slot    (out_edge_slot),
    .out_last_edge    (out_last_edge)
  );

endmodule

// ----- tb/tb_ldpc_check_row_neighbour_generator_core.sv -----
`timescale 1ns / 1ps

module tb_ldpc_check_row_neighbour_generator_core;

  localparam int unsigned RowW  = lcrng_pkg::RowW;
  localparam int unsigned ColW  = lcrng_pkg::ColW;
  localparam int unsigned SlotW = lcrng_pkg::SlotW;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RandomRows = 400;
  localparam int unsigned DrainCycles = 12;

  typedef struct packed {
    logic [ColW-1:0]  column;
    logic [SlotW-1:0] slot;
    logic             last;
  } edge_t;

  class edge_scoreboard;
    edge_t       pending_edges[$];
    int unsigned mismatches = 0;

    int unsigned theta[8] = '{3, 0, 1, 2, 2, 3, 0, 1};
    int unsigned phi[8][4] = '{
      '{16, 0, 0, 0}, '{103, 53, 8, 35}, '{105, 74, 119, 97}, '{0, 45, 89, 112},
      '{50, 47, 31, 64}, '{29, 0, 122, 93}, '{115, 59, 1, 99}, '{30, 102, 69, 94}
    };
    int unsigned degree[3] = '{3, 6, 6};
    // 0 is identity, k is permutation k
    int unsigned block_kind[3][6] = '{
      '{0, 0, 1, 0, 0, 0}, '{0, 0, 0, 2, 3, 4}, '{0, 5, 6, 7, 8, 0}
    };
    int unsigned block_group[3][6] = '{
      '{2, 4, 4, 0, 0, 0}, '{0, 1, 3, 4, 4, 4}, '{0, 1, 1, 3, 3, 4}
    };

    function int unsigned permute_local(int unsigned loc, int unsigned kind);
      int unsigned t;
      int unsigned q;
      t = kind - 1;
      q = loc / 128;
      return 128 * ((theta[t] + q) % 4) + ((phi[t][q] + loc) % 128);
    endfunction

    function void note_row(logic [RowW-1:0] row);
      int unsigned grp;
      int unsigned loc;
      int unsigned mapped_col;
      edge_t e;
      grp = row / 512;
      loc = row % 512;
      if (grp >= 3) return;
      for (int unsigned s = 0; s < degree[grp]; s++) begin
        mapped_col = (block_kind[grp][s] == 0) ? loc : permute_local(loc, block_kind[grp][s]);
        e.column = ColW'(block_group[grp][s] * 512 + mapped_col);
        e.slot = SlotW'(s);
        e.last = (s + 1 == degree[grp]);
        pending_edges.push_back(e);
      end
    endfunction

    function void check_edge(edge_t got);
      edge_t want;
      if (pending_edges.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction: column %0d slot %0d last %0d",
                   got.column, got.slot, got.last);
        return;
      end
      want = pending_edges.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected col %0d slot %0d last %0d, got col %0d slot %0d last %0d",
                   want.column, want.slot, want.last, got.column, got.slot, got.last);
      end
    endfunction

    function int unsigned pending();
      return pending_edges.size();
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [RowW-1:0]  in_row_index;
  logic             out_valid;
  logic             out_stall;
  logic [ColW-1:0]  out_column_index;
  logic [SlotW-1:0] out_edge_slot;
  logic             out_last_edge;

  edge_scoreboard sb;
  bit             no_idle;
  int unsigned    cycles;

  ldpc_check_row_neighbour_generator_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_row_index     (in_row_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_column_index (out_column_index),
    .out_edge_slot    (out_edge_slot),
    .out_last_edge    (out_last_edge)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_row(input logic [RowW-1:0] row);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_row_index <= row;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sb.note_row(row);
    @(negedge clk);
  endtask

  function automatic logic [RowW-1:0] random_row();
    int unsigned pick;
    int unsigned quarter_edges[6] = '{0, 127, 128, 255, 384, 511};
    pick = $urandom_range(0, 9);
    if (pick == 0) return RowW'($urandom_range(1536, 2047));
    if (pick == 1)
      return RowW'(512 * $urandom_range(0, 2) + quarter_edges[$urandom_range(0, 5)]);
    return RowW'($urandom_range(0, 1535));
  endfunction

  initial begin
    int unsigned gap;
    edge_t       got;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      gap = no_idle ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      got.column = out_column_index;
      got.slot   = out_edge_slot;
      got.last   = out_last_edge;
      sb.check_edge(got);
    end
  end

  initial begin
    logic [RowW-1:0] directed_rows[$];
    sb = new();
    no_idle = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_row_index = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    directed_rows = '{11'd0, 11'd511, 11'd512, 11'd1023, 11'd1024, 11'd1535,
                      11'd1536, 11'd2047, 11'd127, 11'd128, 11'd255, 11'd256,
                      11'd383, 11'd384, 11'd640, 11'd767, 11'd896, 11'd1151,
                      11'd1280, 11'd1407, 11'd1408, 11'd1700, 11'd1365, 11'd682};
    foreach (directed_rows[n]) send_row(directed_rows[n]);

    for (int unsigned n = 0; n < RandomRows; n++) begin
      no_idle = (n >= 100 && n < 160);
      if (n == 250) begin
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (DrainCycles) @(negedge clk);
      end
      send_row(random_row());
    end
    no_idle = 1'b0;
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
